// File: sv/assert_macros.svh
// Assertion macros used by the RTL of the fuel ordered priority queue.
// No dependencies; included by fop_datapath, the module that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every rising clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: invariant");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// File: sv/fop_pkg.sv
// Package for the fuel ordered priority queue: payload structs, codes,
// controller/datapath interface types and the popcount helper. No dependencies.
`default_nettype none

package fop_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int FUEL_W        = 16;
    localparam int IN_FUEL_W     = 8;
    localparam int TAG_W         = 16;
    localparam int CNT_W         = 5;
    localparam int ZCHUNK        = 8;
    localparam int ZPOP_W        = $clog2(ZCHUNK + 1);

    localparam logic signed [FUEL_W-1:0] FUEL_MIN = {1'b1, {(FUEL_W-1){1'b0}}};

    typedef enum logic [1:0] {
        KIND_ORDERED = 2'd0,
        KIND_TAIL    = 2'd1,
        KIND_REMOVE  = 2'd2,
        KIND_TICK    = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [IN_FUEL_W-1:0] fuel;
        logic [TAG_W-1:0]     tag;
    } request_t;

    typedef struct packed {
        logic                     accepted;
        logic                     head_valid;
        logic [TAG_W-1:0]         head_tag;
        logic signed [FUEL_W-1:0] head_fuel;
        logic [CNT_W-1:0]         entry_count;
        logic [CNT_W-1:0]         zero_fuel_count;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_UPDATE,
        ST_COUNT,
        ST_REPORT
    } state_t;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_LOAD,
        DP_COMPARE,
        DP_UPDATE,
        DP_COUNT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   report;
    } dp_ctrl_t;

    typedef struct packed {
        logic count_last;
        logic result_ready;
    } dp_status_t;

    function automatic logic [ZPOP_W-1:0] popcount(input logic [ZCHUNK-1:0] v);
        logic [ZPOP_W-1:0] sum;
        sum = '0;
        for (int k = 0; k < ZCHUNK; k++)
        begin
            sum = sum + ZPOP_W'(v[k]);
        end
        return sum;
    endfunction

endpackage

`default_nettype wire

// File: sv/fop_ctrl.sv
// Controller FSM of the fuel ordered priority queue.
// Depends on fop_pkg; drives the datapath through dp_ctrl_t.
`default_nettype none

module fop_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire fop_pkg::dp_status_t status,
    output fop_pkg::dp_ctrl_t       ctrl,
    output logic                    busy,
    output logic                    done
);

    fop_pkg::state_t state_reg;
    fop_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fop_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fop_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = fop_pkg::ST_COMPARE;
                end
            end
            fop_pkg::ST_COMPARE: state_next = fop_pkg::ST_UPDATE;
            fop_pkg::ST_UPDATE:  state_next = fop_pkg::ST_COUNT;
            fop_pkg::ST_COUNT:
            begin
                if (status.count_last)
                begin
                    state_next = fop_pkg::ST_REPORT;
                end
            end
            fop_pkg::ST_REPORT:  state_next = fop_pkg::ST_IDLE;
            default:             state_next = fop_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl.op     = fop_pkg::DP_NOP;
        ctrl.report = 1'b0;
        busy        = 1'b1;
        done        = 1'b0;
        case (state_reg)
            fop_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctrl.op = fop_pkg::DP_LOAD;
                end
            end
            fop_pkg::ST_COMPARE: ctrl.op = fop_pkg::DP_COMPARE;
            fop_pkg::ST_UPDATE:  ctrl.op = fop_pkg::DP_UPDATE;
            fop_pkg::ST_COUNT:   ctrl.op = fop_pkg::DP_COUNT;
            fop_pkg::ST_REPORT:
            begin
                ctrl.report = 1'b1;
                done        = status.result_ready;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/fop_datapath.sv
// Datapath of the fuel ordered priority queue: slot shift array, compare
// vector, occupancy and the chunked zero-fuel counter. Depends on fop_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module fop_datapath #(
    parameter int DEPTH = fop_pkg::DEPTH_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire fop_pkg::request_t   request,
    input  wire fop_pkg::dp_ctrl_t   ctrl,
    output fop_pkg::dp_status_t      status,
    output fop_pkg::result_t         result
);

    localparam int FW     = fop_pkg::FUEL_W;
    localparam int TW     = fop_pkg::TAG_W;
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int NCHUNK = (DEPTH + fop_pkg::ZCHUNK - 1) / fop_pkg::ZCHUNK;
    localparam int CCW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int ZW     = NCHUNK * fop_pkg::ZCHUNK;

    fop_pkg::kind_t              kind_reg;
    logic [fop_pkg::IN_FUEL_W-1:0] fuel_reg;
    logic [TW-1:0]               tag_reg;
    logic [DEPTH-1:0]            lt_reg;
    logic [CW-1:0]               occ_reg;
    logic [CW-1:0]               occ_next;
    logic                        acc_reg;
    logic                        acc_next;
    logic [CW-1:0]               zacc_reg;
    logic [CCW-1:0]              cidx_reg;

    logic signed [FW-1:0]        slot_fuel_reg  [DEPTH];
    logic [TW-1:0]               slot_tag_reg   [DEPTH];
    logic signed [FW-1:0]        slot_fuel_next [DEPTH];
    logic [TW-1:0]               slot_tag_next  [DEPTH];

    logic [DEPTH-1:0]            ahead_lt;
    logic [ZW-1:0]               zflag;
    logic                        full;
    logic                        empty;
    logic signed [FW-1:0]        new_fuel;
    logic [31:0]                 occ_wide;
    logic [31:0]                 zacc_wide;

    assign full     = (occ_reg == CW'(DEPTH));
    assign empty    = (occ_reg == '0);
    assign new_fuel = FW'({1'b0, fuel_reg});

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_slot
        logic signed [FW-1:0] lo_fuel;
        logic signed [FW-1:0] hi_fuel;
        logic [TW-1:0]        lo_tag;
        logic [TW-1:0]        hi_tag;

        if (i == 0)
        begin : g_first
            assign ahead_lt[i] = 1'b1;
            assign lo_fuel     = slot_fuel_reg[i];
            assign lo_tag      = slot_tag_reg[i];
        end
        else
        begin : g_rest
            assign ahead_lt[i] = &lt_reg[i-1:0];
            assign lo_fuel     = slot_fuel_reg[i-1];
            assign lo_tag      = slot_tag_reg[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign hi_fuel = slot_fuel_reg[i];
            assign hi_tag  = slot_tag_reg[i];
        end
        else
        begin : g_mid
            assign hi_fuel = slot_fuel_reg[i+1];
            assign hi_tag  = slot_tag_reg[i+1];
        end

        always_comb
        begin
            slot_fuel_next[i] = slot_fuel_reg[i];
            slot_tag_next[i]  = slot_tag_reg[i];
            if (ctrl.op == fop_pkg::DP_UPDATE)
            begin
                case (kind_reg)
                    fop_pkg::KIND_ORDERED:
                    begin
                        if (!full)
                        begin
                            if (ahead_lt[i] && !lt_reg[i])
                            begin
                                slot_fuel_next[i] = new_fuel;
                                slot_tag_next[i]  = tag_reg;
                            end
                            else if (!ahead_lt[i])
                            begin
                                slot_fuel_next[i] = lo_fuel;
                                slot_tag_next[i]  = lo_tag;
                            end
                        end
                    end
                    fop_pkg::KIND_TAIL:
                    begin
                        if (!full && CW'(i) == occ_reg)
                        begin
                            slot_fuel_next[i] = new_fuel;
                            slot_tag_next[i]  = tag_reg;
                        end
                    end
                    fop_pkg::KIND_REMOVE:
                    begin
                        if (!empty)
                        begin
                            slot_fuel_next[i] = hi_fuel;
                            slot_tag_next[i]  = hi_tag;
                        end
                    end
                    fop_pkg::KIND_TICK:
                    begin
                        if (slot_fuel_reg[i] != fop_pkg::FUEL_MIN)
                        begin
                            slot_fuel_next[i] = slot_fuel_reg[i] - FW'(1);
                        end
                    end
                    default:
                    begin
                        slot_fuel_next[i] = slot_fuel_reg[i];
                    end
                endcase
            end
        end
    end

    for (genvar j = 0; j < ZW; j++)
    begin : g_zflag
        if (j < DEPTH)
        begin : g_used
            assign zflag[j] = (CW'(j) < occ_reg) && (slot_fuel_reg[j] == '0);
        end
        else
        begin : g_pad
            assign zflag[j] = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_fuel_reg[i] <= slot_fuel_next[i];
            slot_tag_reg[i]  <= slot_tag_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.op == fop_pkg::DP_LOAD)
        begin
            kind_reg <= request.kind;
            fuel_reg <= request.fuel;
            tag_reg  <= request.tag;
        end
        if (ctrl.op == fop_pkg::DP_COMPARE)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                lt_reg[i] <= (CW'(i) < occ_reg) && (slot_fuel_reg[i] < new_fuel);
            end
        end
    end

    always_comb
    begin
        occ_next = occ_reg;
        acc_next = 1'b0;
        case (kind_reg)
            fop_pkg::KIND_ORDERED,
            fop_pkg::KIND_TAIL:
            begin
                if (!full)
                begin
                    occ_next = occ_reg + CW'(1);
                    acc_next = 1'b1;
                end
            end
            fop_pkg::KIND_REMOVE:
            begin
                if (!empty)
                begin
                    occ_next = occ_reg - CW'(1);
                    acc_next = 1'b1;
                end
            end
            fop_pkg::KIND_TICK: acc_next = 1'b1;
            default:            acc_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg  <= '0;
            acc_reg  <= 1'b0;
            zacc_reg <= '0;
            cidx_reg <= '0;
        end
        else
        begin
            case (ctrl.op)
                fop_pkg::DP_UPDATE:
                begin
                    occ_reg  <= occ_next;
                    acc_reg  <= acc_next;
                    zacc_reg <= '0;
                    cidx_reg <= '0;
                end
                fop_pkg::DP_COUNT:
                begin
                    zacc_reg <= zacc_reg + CW'(fop_pkg::popcount(
                        zflag[cidx_reg * fop_pkg::ZCHUNK +: fop_pkg::ZCHUNK]));
                    cidx_reg <= cidx_reg + CCW'(1);
                end
                default:
                begin
                    occ_reg <= occ_reg;
                end
            endcase
        end
    end

    assign status.count_last   = (cidx_reg == CCW'(NCHUNK - 1));
    assign status.result_ready = ctrl.report;

    assign occ_wide  = 32'(occ_reg);
    assign zacc_wide = 32'(zacc_reg);

    always_comb
    begin
        result.accepted        = acc_reg;
        result.head_valid      = !empty;
        result.head_tag        = empty ? '0 : slot_tag_reg[0];
        result.head_fuel       = empty ? '0 : slot_fuel_reg[0];
        result.entry_count     = occ_wide[fop_pkg::CNT_W-1:0];
        result.zero_fuel_count = zacc_wide[fop_pkg::CNT_W-1:0];
    end

    `ASSERT_ALWAYS(a_occ_bound, clk, rst_n, occ_reg <= CW'(DEPTH))
    `ASSERT_NEXT(a_occ_hold, clk, rst_n, ctrl.op != fop_pkg::DP_UPDATE, $stable(occ_reg))
    `ASSERT_NEXT(a_insert_grows, clk, rst_n,
        ctrl.op == fop_pkg::DP_UPDATE && kind_reg == fop_pkg::KIND_ORDERED && !full,
        occ_reg == CW'($past(occ_reg) + CW'(1)) && acc_reg)
    `ASSERT_ALWAYS(a_zero_le_occ, clk, rst_n, !ctrl.report || zacc_reg <= occ_reg)

endmodule

`default_nettype wire

// File: sv/fuel_ordered_priority_queue.sv
// Top level of the fuel ordered priority queue: controller plus datapath.
// Depends on fop_pkg, fop_ctrl and fop_datapath.
//
// One transaction is taken when start is high while busy is low; its result is
// shown for exactly one cycle with done high and must be captured then, since
// this block cannot be held off. busy falls in the cycle after done, and a new
// transaction is taken only once the last one is through. Each transaction
// steps through a compare of all slots, a parallel shift/update over all
// slots, and the zero-fuel count, which sums eight slots per cycle, before
// its result is reported.
`default_nettype none

module fuel_ordered_priority_queue #(
    parameter int DEPTH = fop_pkg::DEPTH_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire fop_pkg::request_t request,
    output logic                   busy,
    output logic                   done,
    output fop_pkg::result_t       result
);

    fop_pkg::dp_ctrl_t   ctrl;
    fop_pkg::dp_status_t status;

    fop_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .ctrl   (ctrl),
        .busy   (busy),
        .done   (done)
    );

    fop_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .ctrl    (ctrl),
        .status  (status),
        .result  (result)
    );

endmodule

`default_nettype wire
